[rtl/core/cbat_pkg.sv]
// ----------------------------------------------------------------------------
// cbat_pkg - shared types and constants for the CORDIC bearing unit
// Widths, the arctangent step table and the pipeline payload struct.
// ----------------------------------------------------------------------------
`default_nettype none

package cbat_pkg;

	// number of vectoring iterations (1..16)
	localparam int ITERATIONS = 16;

	// field widths
	localparam int COORD_W = 32;
	localparam int ANG_W   = 32;
	localparam int DIFF_W  = COORD_W + 1;
	// datapath width: difference, negation and CORDIC gain headroom
	localparam int CW      = COORD_W + 4;
	localparam int IDX_W   = 4;

	// quarter-turn offset codes, top two bits of the angle
	localparam logic [1:0] QUAD_NONE = 2'b00;
	localparam logic [1:0] QUAD_POS  = 2'b01;
	localparam logic [1:0] QUAD_NEG  = 2'b11;

	// payload carried between pipeline stages
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [ANG_W-1:0]     ang;
		logic [1:0]           quad;
	} cord_t;

	// arctan(2^-i), full turn = 2^32
	function automatic logic [ANG_W-1:0] atan_step(input logic [IDX_W-1:0] i);
		logic [ANG_W-1:0] v;
		unique case (i)
			4'd0:    v = 32'd536870912;
			4'd1:    v = 32'd316933406;
			4'd2:    v = 32'd167458907;
			4'd3:    v = 32'd85004756;
			4'd4:    v = 32'd42667331;
			4'd5:    v = 32'd21354465;
			4'd6:    v = 32'd10679838;
			4'd7:    v = 32'd5340245;
			4'd8:    v = 32'd2670163;
			4'd9:    v = 32'd1335087;
			4'd10:   v = 32'd667544;
			4'd11:   v = 32'd333772;
			4'd12:   v = 32'd166886;
			4'd13:   v = 32'd83443;
			4'd14:   v = 32'd41722;
			default: v = 32'd20861;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

[rtl/core/cbat_prep.sv]
// ----------------------------------------------------------------------------
// cbat_prep - difference and half-plane fold
// Stage 1 forms dx and -dy; stage 2 turns left-half-plane vectors by a
// quarter turn and records the offset to add back.
// ----------------------------------------------------------------------------
`default_nettype none

module cbat_prep
	import cbat_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                in_vld,
	input  wire logic [COORD_W-1:0]  from_x,
	input  wire logic [COORD_W-1:0]  from_y,
	input  wire logic [COORD_W-1:0]  to_x,
	input  wire logic [COORD_W-1:0]  to_y,
	output logic                     out_vld,
	output cord_t                    out_dat
);

	logic                     vld_s1;
	logic signed [DIFF_W-1:0] dx_s1;
	logic signed [DIFF_W-1:0] dy_s1;
	logic                     vld_s2;
	cord_t                    dat_s2;

	logic signed [CW-1:0] dx_w;
	logic signed [CW-1:0] dy_w;
	cord_t                fold;

	// stage 1 and stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	// stage 1: dx = to_x - from_x, dy = from_y - to_y (screen y flipped)
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= $signed({to_x[COORD_W-1], to_x}) - $signed({from_x[COORD_W-1], from_x});
			dy_s1 <= $signed({from_y[COORD_W-1], from_y}) - $signed({to_y[COORD_W-1], to_y});
		end
	end

	// fold into the right half plane
	assign dx_w = CW'(dx_s1);
	assign dy_w = CW'(dy_s1);

	always_comb begin
		fold.ang = '0;
		if (dx_w[CW-1]) begin
			if (!dy_w[CW-1]) begin
				fold.x    = dy_w;
				fold.y    = -dx_w;
				fold.quad = QUAD_POS;
			end else begin
				fold.x    = -dy_w;
				fold.y    = dx_w;
				fold.quad = QUAD_NEG;
			end
		end else begin
			fold.x    = dx_w;
			fold.y    = dy_w;
			fold.quad = QUAD_NONE;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (en) begin
			dat_s2 <= fold;
		end
	end

	assign out_vld = vld_s2;
	assign out_dat = dat_s2;

endmodule

`default_nettype wire

[rtl/core/cbat_stage.sv]
// ----------------------------------------------------------------------------
// cbat_stage - one CORDIC vectoring iteration
// Shift-add micro-rotation toward the x axis with a register behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module cbat_stage
	import cbat_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic [IDX_W-1:0] idx,
	input  wire logic             in_vld,
	input  wire cord_t            in_dat,
	output logic                  out_vld,
	output cord_t                 out_dat
);

	logic  vld_s1;
	cord_t dat_s1;

	logic signed [CW-1:0] sx;
	logic signed [CW-1:0] sy;
	logic [ANG_W-1:0]     step;
	cord_t                nxt;

	// micro-rotation; y == 0 leaves everything as is
	always_comb begin
		sx   = $signed(in_dat.x) >>> idx;
		sy   = $signed(in_dat.y) >>> idx;
		step = atan_step(idx);
		nxt  = in_dat;
		if (in_dat.y[CW-1]) begin
			nxt.x   = in_dat.x - sy;
			nxt.y   = in_dat.y + sx;
			nxt.ang = in_dat.ang - step;
		end else if (in_dat.y != '0) begin
			nxt.x   = in_dat.x + sy;
			nxt.y   = in_dat.y - sx;
			nxt.ang = in_dat.ang + step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_s1 <= nxt;
		end
	end

	assign out_vld = vld_s1;
	assign out_dat = dat_s1;

endmodule

`default_nettype wire

[rtl/core/cordic_bearing_atan2.sv]
// ----------------------------------------------------------------------------
// cordic_bearing_atan2 - bearing between two 16.16 points by CORDIC
// Pipelined atan2: difference, half-plane fold, one iteration per stage,
// quarter-turn offset and output register.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit first)              | width
//  s_*     | in  | from_x, from_y, to_x, to_y (signed 16.16)  | 128
//  m_*     | out | bearing (unsigned, 2^32 = full turn)       | 32
//
//  One request enters per cycle while the output is not stalled; the pipe
//  has two prep stages, one per CORDIC iteration, then an output register.
//  The depth is set by the iteration chain, one add/sub stage each.
//  Reset clears only the valid bits; payload registers are not reset.
//  A stall at m_tready freezes the whole pipeline; s_tready follows it.
// ----------------------------------------------------------------------------
`default_nettype none

module cordic_bearing_atan2
	import cbat_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [4*COORD_W-1:0] s_tdata,  // from_x, from_y, to_x, to_y
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [ANG_W-1:0]          m_tdata   // bearing
);

	logic  en;
	logic  vld [0:ITERATIONS];
	cord_t dat [0:ITERATIONS];

	logic             out_vld_q;
	logic [ANG_W-1:0] bearing_q;

	// whole pipe advances when the output slot is free or being taken
	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;

	// difference and fold
	cbat_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (s_tvalid),
		.from_x  (s_tdata[COORD_W-1:0]),
		.from_y  (s_tdata[2*COORD_W-1:COORD_W]),
		.to_x    (s_tdata[3*COORD_W-1:2*COORD_W]),
		.to_y    (s_tdata[4*COORD_W-1:3*COORD_W]),
		.out_vld (vld[0]),
		.out_dat (dat[0])
	);

	// iteration chain
	for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
		cbat_stage u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.idx     (IDX_W'(i)),
			.in_vld  (vld[i]),
			.in_dat  (dat[i]),
			.out_vld (vld[i+1]),
			.out_dat (dat[i+1])
		);
	end

	// add back quarter-turn offset, modulo 2^32
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld[ITERATIONS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bearing_q <= dat[ITERATIONS].ang + {dat[ITERATIONS].quad, {(ANG_W-2){1'b0}}};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = bearing_q;

endmodule

`default_nettype wire

[rtl/core/cbat_checker.sv]
// ----------------------------------------------------------------------------
// cbat_checker - port-level checks for the bearing unit
// Output hold under backpressure, stall coupling, reset behavior, X checks.
// ----------------------------------------------------------------------------
`default_nettype none

module cbat_checker
	import cbat_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tvalid,
	input wire logic                 s_tready,
	input wire logic [4*COORD_W-1:0] s_tdata,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [ANG_W-1:0]     m_tdata
);

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// a stalled result keeps its value
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	// input side is open exactly when the output slot can move
	a_ready_link: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready not tied to output slot");

	// nothing comes out right after reset leaves
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result present after reset");

	// valids are known, and offered data on either side is known
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({s_tvalid, m_tvalid}) &&
		(!s_tvalid || !$isunknown(s_tdata)) &&
		(!m_tvalid || !$isunknown(m_tdata)))
		else $error("unknown value on an offered request or result");

endmodule

bind cordic_bearing_atan2 cbat_checker u_cbat_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
